@@ rtl/lcfd_pkg.sv @@
// Shared constants and types of the length/checksum frame deframer.
package lcfd_pkg;

    // Longest frame kept; longer declared frames are cut here (16..256).
    localparam int MAX_FRAME    = 256;
    localparam int FRAME_LIMIT  = (MAX_FRAME > 256) ? 256 : MAX_FRAME;
    localparam int MIN_FRAME    = 5;
    localparam int HEADER_BYTES = 9;

    // Byte kinds reported with every echoed byte.
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_CHECKSUM = 2'd2;

    // Header byte positions.
    localparam logic [7:0] POS_DIRECTION = 8'd0;
    localparam logic [7:0] POS_ID_LO     = 8'd1;
    localparam logic [7:0] POS_ID_HI     = 8'd2;
    localparam logic [7:0] POS_LEN_LO    = 8'd3;
    localparam logic [7:0] POS_LEN_HI    = 8'd4;
    localparam logic [7:0] POS_GROUP     = 8'd5;
    localparam logic [7:0] POS_DEVICE    = 8'd6;
    localparam logic [7:0] POS_CMD_LO    = 8'd7;
    localparam logic [7:0] POS_CMD_HI    = 8'd8;

    typedef struct packed {
        logic [7:0]  direction;
        logic [15:0] device_id;
        logic [15:0] length_field;
        logic [7:0]  group_address;
        logic [7:0]  device_address;
        logic [15:0] command_code;
    } header_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [1:0]  byte_kind;
        logic        frame_last;
        logic        checksum_ok;
        logic        too_long;
        logic [7:0]  direction;
        logic [15:0] device_id;
        logic [15:0] length_field;
        logic [7:0]  group_address;
        logic [7:0]  device_address;
        logic [15:0] command_code;
    } frame_result_t;

endpackage

@@ rtl/lcfd_if.sv @@
// Valid/ready channel interfaces for received bytes and framed results.
interface lcfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcfd_out_if;
    logic                   valid;
    logic                   ready;
    lcfd_pkg::frame_result_t result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

@@ rtl/lcfd_frame_tracker.sv @@
// Frame position, running checksum and header capture for each received byte.
module lcfd_frame_tracker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              rx_byte,
    output lcfd_pkg::frame_result_t result
);
    import lcfd_pkg::*;

    logic [7:0] position_reg;
    logic [7:0] position_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    header_t    held_reg;
    header_t    held_next;

    logic [8:0]  count;
    logic [16:0] declared;
    logic        reach_declared;
    logic        reach_limit;
    logic        last;
    logic        cut;
    logic [7:0]  sum_new;

    always_comb
    begin
        held_next = held_reg;
        unique case (position_reg)
            POS_DIRECTION:
            begin
                held_next           = '0;
                held_next.direction = rx_byte;
            end
            POS_ID_LO:  held_next.device_id[7:0]     = rx_byte;
            POS_ID_HI:  held_next.device_id[15:8]    = rx_byte;
            POS_LEN_LO: held_next.length_field[7:0]  = rx_byte;
            POS_LEN_HI: held_next.length_field[15:8] = rx_byte;
            POS_GROUP:  held_next.group_address      = rx_byte;
            POS_DEVICE: held_next.device_address     = rx_byte;
            POS_CMD_LO: held_next.command_code[7:0]  = rx_byte;
            POS_CMD_HI: held_next.command_code[15:8] = rx_byte;
            default: ;
        endcase

        sum_new        = sum_reg + rx_byte;
        count          = {1'b0, position_reg} + 9'd1;
        declared       = 17'(MIN_FRAME) + {1'b0, held_next.length_field};
        reach_declared = ({8'b0, count} >= declared);
        reach_limit    = (count >= 9'(FRAME_LIMIT));
        last           = (count >= 9'(MIN_FRAME)) && (reach_declared || reach_limit);
        cut            = (count >= 9'(MIN_FRAME)) && !reach_declared && reach_limit;

        result            = '0;
        result.data_byte  = rx_byte;
        result.byte_index = position_reg;
        result.frame_last = last;
        if (last)
        begin
            result.byte_kind      = KIND_CHECKSUM;
            result.checksum_ok    = (sum_new == 8'd0);
            result.too_long       = cut;
            result.direction      = held_next.direction;
            result.device_id      = held_next.device_id;
            result.length_field   = held_next.length_field;
            result.group_address  = held_next.group_address;
            result.device_address = held_next.device_address;
            result.command_code   = held_next.command_code;
        end
        else if (position_reg < 8'(HEADER_BYTES))
        begin
            result.byte_kind = KIND_HEADER;
        end
        else
        begin
            result.byte_kind = KIND_PAYLOAD;
        end

        position_next = last ? 8'd0 : count[7:0];
        sum_next      = last ? 8'd0 : sum_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            sum_reg      <= '0;
            held_reg     <= '0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            sum_reg      <= sum_next;
            held_reg     <= held_next;
        end
    end

endmodule

@@ rtl/lcfd_out_stage.sv @@
// Result register that holds one framed byte until the receiver takes it.
module lcfd_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  lcfd_pkg::frame_result_t load_data,
    input  logic                    take,
    output logic                    valid,
    output lcfd_pkg::frame_result_t data
);
    import lcfd_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    frame_result_t data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

@@ rtl/length_checksum_frame_deframer.sv @@
// Top level of the length/checksum frame deframer.
//
// rx carries one received serial byte per request; tx returns one result per
// byte: the byte echoed with its index in the frame and its kind (header,
// payload, checksum). A frame is a 9-byte header (direction, device id,
// length, group, device, command; 16-bit fields little-endian), payload and
// a checksum byte, 5 + length bytes in all and never fewer than 5. The byte
// that ends a frame carries checksum_ok (all frame bytes sum to zero mod
// 256), too_long (frame cut at MAX_FRAME bytes) and the captured header.
//
// Each accepted byte is registered and offered on tx in the cycle after it
// is accepted. Throughput is one byte per cycle, limited by the single result
// register; rx.ready stays high while that register is empty or being taken.
// When the receiver stalls, the result is held and rx.ready drops until it
// is taken. Reset puts the block at the start of a frame with a cleared
// checksum and header, and empties the result register.
module length_checksum_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    lcfd_in_if.sink    rx,
    lcfd_out_if.source tx
);
    import lcfd_pkg::*;

    logic          accept;
    frame_result_t step_result;
    logic          out_valid;
    frame_result_t out_data;

    // Take a new byte whenever the result register is free this cycle.
    assign rx.ready = !out_valid || tx.ready;
    assign accept   = rx.valid && rx.ready;

    lcfd_frame_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .result  (step_result)
    );

    lcfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (step_result),
        .take      (tx.ready),
        .valid     (out_valid),
        .data      (out_data)
    );

    assign tx.valid  = out_valid;
    assign tx.result = out_data;

`ifndef SYNTHESIS
    // Every accepted byte shows up on tx at the next edge.
    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> tx.valid)
        else $error("accepted byte not presented on tx");

    a_last_is_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.result.frame_last) |-> (tx.result.byte_kind == KIND_CHECKSUM))
        else $error("frame end without checksum kind");

    a_last_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.result.frame_last) |-> (tx.result.byte_index >= 8'(MIN_FRAME - 1)))
        else $error("frame ended before minimum length");

    a_flags_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && !tx.result.frame_last) |->
            (!tx.result.checksum_ok && !tx.result.too_long && tx.result.direction == 8'd0))
        else $error("end-of-frame fields set on inner byte");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.ready && !tx.result.frame_last && accept) |=>
            (tx.result.byte_index == $past(tx.result.byte_index) + 8'd1))
        else $error("byte index did not advance");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the length/checksum frame deframer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcfd_pkg::*;

    // Run length guard and settle time after the last result.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_BYTES = 110;
    localparam int CLEAN_BYTES  = 40;

    logic clk;
    logic rst_n;

    lcfd_in_if  rx_ch ();
    lcfd_out_if tx_ch ();

    length_checksum_frame_deframer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shared run state. gaps_on enables random idle bursts on both channels;
    // hold_asked makes the receiver refuse results for a long stretch once.
    bit              gaps_on;
    bit              hold_asked;
    int              mismatch_count;
    int              bytes_sent;
    int              cycle_count;
    frame_result_t   pending_results[$];

    // Mirror of the deframer: position within the frame, running sum and the
    // header fields captured so far.
    logic [7:0]      frame_pos;
    logic [7:0]      frame_sum;
    header_t         held_hdr;

    // Works out the result for one accepted byte and advances the mirror.
    function automatic frame_result_t deframe_byte(input logic [7:0] b);
        frame_result_t r;
        int            count;
        bit            last;
        bit            cut;
        r     = '0;
        count = int'(frame_pos) + 1;
        // Header capture; byte 0 clears every held field so that a short
        // frame reports the fields it never received as zero.
        case (frame_pos)
            POS_DIRECTION:
            begin
                held_hdr           = '0;
                held_hdr.direction = b;
            end
            POS_ID_LO:  held_hdr.device_id[7:0]     = b;
            POS_ID_HI:  held_hdr.device_id[15:8]    = b;
            POS_LEN_LO: held_hdr.length_field[7:0]  = b;
            POS_LEN_HI: held_hdr.length_field[15:8] = b;
            POS_GROUP:  held_hdr.group_address      = b;
            POS_DEVICE: held_hdr.device_address     = b;
            POS_CMD_LO: held_hdr.command_code[7:0]  = b;
            POS_CMD_HI: held_hdr.command_code[15:8] = b;
            default: ;
        endcase
        frame_sum = frame_sum + b;
        last = 1'b0;
        cut  = 1'b0;
        // Never ends before byte 4; a declared size past the limit is cut.
        if (count >= MIN_FRAME)
        begin
            if (count >= MIN_FRAME + int'(held_hdr.length_field))
                last = 1'b1;
            else if (count >= FRAME_LIMIT)
            begin
                last = 1'b1;
                cut  = 1'b1;
            end
        end
        r.data_byte  = b;
        r.byte_index = frame_pos;
        // The closing byte is always the checksum kind, even inside the header.
        if (last)
            r.byte_kind = KIND_CHECKSUM;
        else if (frame_pos < HEADER_BYTES)
            r.byte_kind = KIND_HEADER;
        else
            r.byte_kind = KIND_PAYLOAD;
        r.frame_last = last;
        if (last)
        begin
            r.checksum_ok    = (frame_sum == 8'd0);
            r.too_long       = cut;
            r.direction      = held_hdr.direction;
            r.device_id      = held_hdr.device_id;
            r.length_field   = held_hdr.length_field;
            r.group_address  = held_hdr.group_address;
            r.device_address = held_hdr.device_address;
            r.command_code   = held_hdr.command_code;
            frame_pos = 8'd0;
            frame_sum = 8'd0;
        end
        else
            frame_pos = frame_pos + 8'd1;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Cycle guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[length_checksum_frame_deframer] ERROR");
            $finish;
        end
    end

    // Every accepted request feeds the mirror; values sampled here are the
    // ones settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n && rx_ch.valid && rx_ch.ready)
            pending_results.push_back(deframe_byte(rx_ch.rx_byte));
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        frame_result_t got;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            got = tx_ch.result;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: byte 0x%0h index %0d",
                       got.data_byte, got.byte_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("data_byte",      16'(want.data_byte),      16'(got.data_byte));
                check_field("byte_index",     16'(want.byte_index),     16'(got.byte_index));
                check_field("byte_kind",      16'(want.byte_kind),      16'(got.byte_kind));
                check_field("frame_last",     16'(want.frame_last),     16'(got.frame_last));
                check_field("checksum_ok",    16'(want.checksum_ok),    16'(got.checksum_ok));
                check_field("too_long",       16'(want.too_long),       16'(got.too_long));
                check_field("direction",      16'(want.direction),      16'(got.direction));
                check_field("device_id",      want.device_id,           got.device_id);
                check_field("length_field",   want.length_field,        got.length_field);
                check_field("group_address",  16'(want.group_address),  16'(got.group_address));
                check_field("device_address", 16'(want.device_address),
                            16'(got.device_address));
                check_field("command_code",   want.command_code,        got.command_code);
            end
        end
    end

    // Receiver side: random stall bursts while gaps are on, plus one long
    // hold-off on request so that the result register fills and rx stalls.
    initial
    begin : result_sink
        int hold_left;
        int stall_left;
        bit hold_taken;
        hold_left  = 0;
        stall_left = 0;
        hold_taken = 1'b0;
        tx_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_asked && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                tx_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                tx_ch.ready <= 1'b0;
            end
            else
                tx_ch.ready <= 1'b1;
        end
    end

    // Offers one byte and returns once it is accepted, sometimes followed by
    // an idle burst. Called at a rising edge; valid stays up between bytes unless an idle burst follows.
    task automatic send_byte(input logic [7:0] b);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!(rx_ch.valid && rx_ch.ready));
        bytes_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Sends one frame built from a header: the header bytes that fit, random
    // payload, and, if asked, a closing byte that brings the sum to zero.
    task automatic send_frame(input header_t h, input bit good_sum);
        logic [7:0]  fb[$];
        logic [71:0] hb;
        logic [7:0]  s;
        int          total;
        int          fix;
        hb    = {h.command_code, h.device_address, h.group_address,
                 h.length_field, h.device_id, h.direction};
        total = MIN_FRAME + int'(h.length_field);
        if (total > FRAME_LIMIT)
            total = FRAME_LIMIT;
        for (int i = 0; i < total; i++)
            fb.push_back(i < HEADER_BYTES ? hb[8*i +: 8] : 8'($urandom));
        if (good_sum)
        begin
            // Byte 4 is the length high byte and must keep its value, so a
            // five-byte frame balances its sum through the direction byte.
            fix = (total - 1 == int'(POS_LEN_HI)) ? int'(POS_DIRECTION) : total - 1;
            fb[fix] = 8'd0;
            s = 8'd0;
            foreach (fb[i])
                s = s + fb[i];
            fb[fix] = ~s + 8'd1;
        end
        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    function automatic header_t random_header(input logic [15:0] len);
        header_t h;
        h.direction      = ($urandom_range(0, 9) < 8) ?
                           (($urandom_range(0, 1) == 0) ? 8'haa : 8'hab) : 8'($urandom);
        h.device_id      = 16'($urandom);
        h.length_field   = len;
        h.group_address  = 8'($urandom);
        h.device_address = 8'($urandom);
        h.command_code   = 16'($urandom);
        return h;
    endfunction

    // Shortest frames: length zero, with a good and a bad checksum; the
    // frame ends inside the header at byte 4.
    task automatic test_minimum_frame();
        send_frame(random_header(16'd0), 1'b1);
        send_frame(random_header(16'd0), 1'b0);
    endtask

    // Frames ending at bytes 5..7, before the header is complete; the missing
    // fields must read zero.
    task automatic test_short_headers();
        header_t h;
        h = '{direction: 8'hff, device_id: 16'hffff, length_field: 16'd1,
              group_address: 8'hff, device_address: 8'hff, command_code: 16'hffff};
        send_frame(h, 1'b1);
        h.length_field = 16'd3;
        send_frame(h, 1'b0);
        send_frame(random_header(16'd2), 1'b1);
    endtask

    // Header ending exactly at byte 8, then a frame with payload, with the header
    // fields other than the length set to their lowest and highest values.
    task automatic test_header_and_payload();
        header_t h;
        h = '{direction: 8'h00, device_id: 16'h0000, length_field: 16'd4,
              group_address: 8'h00, device_address: 8'h00, command_code: 16'h0000};
        send_frame(h, 1'b1);
        h = '{direction: 8'hff, device_id: 16'hffff, length_field: 16'd6,
              group_address: 8'hff, device_address: 8'hff, command_code: 16'hffff};
        send_frame(h, 1'b1);
    endtask

    // Frame exactly at the limit, then the largest declared length, which is
    // cut at the limit and flagged.
    task automatic test_too_long();
        send_frame(random_header(16'(FRAME_LIMIT - MIN_FRAME)), 1'b1);
        send_frame(random_header(16'hffff), 1'b1);
    endtask

    // Receiver holds off for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        gaps_on    = 1'b0;
        hold_asked = 1'b1;
        repeat (3)
            send_frame(random_header(16'($urandom_range(2, 6))), 1'b1);
        gaps_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, some bad checksums,
    // some longer payloads and some raw noise.
    task automatic test_random_frames(input int count);
        int stop_at;
        int pick;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                gaps_on = ~gaps_on;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(random_header(16'($urandom_range(0, 24))), $urandom_range(0, 9) < 7);
            else if (pick < 85)
                send_frame(random_header(16'($urandom_range(0, 3))), 1'($urandom_range(0, 1)));
            else if (pick < 88)
                send_frame(random_header(16'($urandom_range(25, 60))), 1'($urandom_range(0, 1)));
            else if (pick < 95)
                send_frame(random_header(16'($urandom_range(7, 60))), 1'b0);
            else
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom_range(0, 2)));
        end
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_no_gaps(input int count);
        int stop_at;
        gaps_on = 1'b0;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_frame(random_header(16'($urandom_range(0, 12))), 1'b1);
        // Frames end on a boundary, so the mirror starts the next one cleanly.
    endtask

    initial
    begin
        frame_pos      = 8'd0;
        frame_sum      = 8'd0;
        held_hdr       = '0;
        gaps_on        = 1'b1;
        hold_asked     = 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_minimum_frame();
        test_short_headers();
        test_header_and_payload();
        test_too_long();
        test_backpressure();
        test_random_frames(RANDOM_BYTES);
        test_no_gaps(CLEAN_BYTES);

        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[length_checksum_frame_deframer] OK");
        else
            $display("[length_checksum_frame_deframer] ERROR");
        $finish;
    end

endmodule
